/* design/key_debounce_event_queue_assert.svh */
// Assertion macros for the key debounce event queue checker.
// Clocked on aclk, disabled while aresetn is low.
`ifndef KEY_DEBOUNCE_EVENT_QUEUE_ASSERT_SVH
`define KEY_DEBOUNCE_EVENT_QUEUE_ASSERT_SVH

// same-cycle implication
`define KDEQ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define KDEQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/kdeq_pkg.sv */
// Shared constants, payload types and control types of the key debounce event queue.
// No dependencies.
package kdeq_pkg;

    localparam int MAX_KEYS    = 10;
    localparam int QUEUE_DEPTH = 13;

    localparam int BITS_W     = 10;
    localparam int KCNT_W     = 4;
    localparam int FILT_W     = 8;
    localparam int HOLD_W     = 16;
    localparam int NUM_W      = 4;
    localparam int KIND_W     = 2;
    localparam int PEND_W     = 4;
    localparam int ENTRY_W    = NUM_W + KIND_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int KEY_W  = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [KIND_W-1:0] KIND_PRESS       = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RELEASE     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_LONG_FIRST  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_LONG_SECOND = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_COUNT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_FIRST  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_SECOND = 2'd3;

    localparam logic [KCNT_W-1:0] RST_KEY_COUNT   = 4'd2;
    localparam logic [FILT_W-1:0] RST_FILTER      = 8'd5;
    localparam logic [HOLD_W-1:0] RST_LONG_FIRST  = 16'd200;
    localparam logic [HOLD_W-1:0] RST_LONG_SECOND = 16'd400;
    localparam logic [HOLD_W-1:0] HOLD_MAX        = 16'hFFFF;

    typedef struct packed {
        logic              func;
        logic [BITS_W-1:0] pressed_bits;
    } kdeq_in_t;

    typedef struct packed {
        logic              queue_empty;
        logic [NUM_W-1:0]  key_number;
        logic [KIND_W-1:0] event_kind;
        logic [PEND_W-1:0] pending_count;
    } kdeq_out_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SECOND,
        ST_READ
    } kdeq_state_t;

    typedef struct packed {
        logic load;
        logic scan;
        logic push_second;
        logic pop;
    } kdeq_cmd_t;

    typedef struct packed {
        logic keys_none;
        logic scan_last;
        logic need_second;
    } kdeq_status_t;

endpackage

/* design/key_debounce_event_queue.sv */
// Channel  | Ports                         | Carries
// ---------+-------------------------------+---------------------------------------
// input    | s_valid s_ready s_data        | scan tick with key samples, or read
// result   | m_valid m_ready m_data        | one popped event or empty flag per read
// config   | cfg_we cfg_index cfg_wdata    | key count, filter, long thresholds
//
// A tick is latched in the idle state; the walk then visits one key state per cycle,
// pausing for an extra queue write after each key that fires both long-press events.
// A read moves to the read state and waits there while a previous result is unread.
// Synchronous reset clears all key state and the queue.
// A tick is accepted while an earlier result still waits on m_ready.
// Top level; depends on kdeq_pkg, kdeq_ctrl and kdeq_datapath.
module key_debounce_event_queue (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [kdeq_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [kdeq_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  kdeq_pkg::kdeq_in_t              s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output kdeq_pkg::kdeq_out_t             m_data
);
    import kdeq_pkg::*;

    kdeq_cmd_t    cmd;
    kdeq_status_t status;

    kdeq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_func  (s_data.func),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    kdeq_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_data    (s_data),
        .cmd       (cmd),
        .status    (status),
        .m_data    (m_data)
    );

endmodule

/* design/kdeq_datapath.sv */
// Datapath: configuration registers, per-key debounce state, event queue, result register.
// Depends on kdeq_pkg; driven by kdeq_ctrl commands.
module kdeq_datapath (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [kdeq_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [kdeq_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  kdeq_pkg::kdeq_in_t                 s_data,
    input  kdeq_pkg::kdeq_cmd_t                cmd,
    output kdeq_pkg::kdeq_status_t             status,
    output kdeq_pkg::kdeq_out_t                m_data
);
    import kdeq_pkg::*;

    logic [KCNT_W-1:0] key_count_reg;
    logic [FILT_W-1:0] filter_ticks_reg;
    logic [HOLD_W-1:0] long_first_reg;
    logic [HOLD_W-1:0] long_second_reg;

    logic              filtering_reg [MAX_KEYS];
    logic              last_reg      [MAX_KEYS];
    logic [FILT_W-1:0] fc_reg        [MAX_KEYS];
    logic [HOLD_W-1:0] hc_reg        [MAX_KEYS];

    logic [ENTRY_W-1:0] store_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  rp_reg;
    logic [QPTR_W-1:0]  wp_reg;
    logic [QCNT_W-1:0]  cnt_reg;

    logic [BITS_W-1:0] bits_reg;
    logic [KEY_W-1:0]  k_reg;
    logic [KEY_W-1:0]  sec_key_reg;
    kdeq_out_t         out_reg;

    logic [MAX_KEYS-1:0] samp;
    logic [KCNT_W-1:0]   n_eff;
    logic                now;
    logic                filt;
    logic                last;
    logic [FILT_W-1:0]   fc;
    logic [HOLD_W-1:0]   hc;
    logic [FILT_W-1:0]   fc_inc;
    logic [HOLD_W-1:0]   hc_inc;
    logic                f_next;
    logic                l_next;
    logic [FILT_W-1:0]   fc_next;
    logic [HOLD_W-1:0]   hc_next;
    logic                hit_first;
    logic                hit_second;
    logic                scan_push;
    logic [KIND_W-1:0]   scan_kind;
    logic                do_push;
    logic [NUM_W-1:0]    push_num;
    logic [KIND_W-1:0]   push_kind;
    logic                q_full;
    logic                q_empty;
    logic [ENTRY_W-1:0]  head;

    always_comb begin
        for (int i = 0; i < MAX_KEYS; i++) begin
            samp[i] = (i < BITS_W) ? bits_reg[i] : 1'b0;
        end
    end

    assign n_eff = (key_count_reg > KCNT_W'(MAX_KEYS)) ? KCNT_W'(MAX_KEYS) : key_count_reg;

    assign now    = samp[k_reg];
    assign filt   = filtering_reg[k_reg];
    assign last   = last_reg[k_reg];
    assign fc     = fc_reg[k_reg];
    assign hc     = hc_reg[k_reg];
    assign fc_inc = fc + FILT_W'(1);
    assign hc_inc = hc + HOLD_W'(1);

    always_comb begin
        f_next     = filt;
        l_next     = last;
        fc_next    = fc;
        hc_next    = hc;
        hit_first  = 1'b0;
        hit_second = 1'b0;
        scan_push  = 1'b0;
        scan_kind  = KIND_PRESS;
        if (!filt) begin
            if (now != last) begin
                l_next  = now;
                fc_next = '0;
                f_next  = 1'b1;
            end else if (now && (hc != HOLD_MAX)) begin
                hc_next    = hc_inc;
                hit_first  = (hc_inc == long_first_reg);
                hit_second = (hc_inc == long_second_reg);
                scan_push  = hit_first || hit_second;
                scan_kind  = hit_first ? KIND_LONG_FIRST : KIND_LONG_SECOND;
            end
        end else if (now == last) begin
            fc_next = fc_inc;
            if (fc_inc >= filter_ticks_reg) begin
                scan_push = 1'b1;
                scan_kind = now ? KIND_PRESS : KIND_RELEASE;
                if (now) begin
                    hc_next = '0;
                end
                f_next = 1'b0;
            end
        end else begin
            l_next = now;
            f_next = 1'b0;
        end
    end

    assign status.keys_none   = (n_eff == '0);
    assign status.scan_last   = (KCNT_W'(k_reg) == n_eff - KCNT_W'(1));
    assign status.need_second = hit_first && hit_second;

    assign do_push   = (cmd.scan && scan_push) || cmd.push_second;
    assign push_num  = cmd.push_second ? NUM_W'(sec_key_reg) + NUM_W'(1)
                                       : NUM_W'(k_reg) + NUM_W'(1);
    assign push_kind = cmd.push_second ? KIND_LONG_SECOND : scan_kind;
    assign q_full    = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_empty   = (cnt_reg == '0);
    assign head      = store_mem[rp_reg];

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_count_reg    <= RST_KEY_COUNT;
            filter_ticks_reg <= RST_FILTER;
            long_first_reg   <= RST_LONG_FIRST;
            long_second_reg  <= RST_LONG_SECOND;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_KEY_COUNT:   key_count_reg    <= cfg_wdata[KCNT_W-1:0];
                CFG_FILTER:      filter_ticks_reg <= cfg_wdata[FILT_W-1:0];
                CFG_LONG_FIRST:  long_first_reg   <= cfg_wdata[HOLD_W-1:0];
                CFG_LONG_SECOND: long_second_reg  <= cfg_wdata[HOLD_W-1:0];
            endcase
        end
    end

    // per-key debounce state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAX_KEYS; i++) begin
                filtering_reg[i] <= 1'b0;
                last_reg[i]      <= 1'b0;
                fc_reg[i]        <= '0;
                hc_reg[i]        <= '0;
            end
        end else if (cmd.scan) begin
            filtering_reg[k_reg] <= f_next;
            last_reg[k_reg]      <= l_next;
            fc_reg[k_reg]        <= fc_next;
            hc_reg[k_reg]        <= hc_next;
        end
    end

    // walk index and latched samples
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            bits_reg <= s_data.pressed_bits;
            k_reg    <= '0;
        end else if (cmd.scan) begin
            k_reg       <= k_reg + KEY_W'(1);
            sec_key_reg <= k_reg;
        end
    end

    // event queue storage
    always_ff @(posedge aclk) begin
        if (do_push && !q_full) begin
            store_mem[wp_reg] <= {push_num, push_kind};
        end
    end

    // queue pointers and count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rp_reg  <= '0;
            wp_reg  <= '0;
            cnt_reg <= '0;
        end else if (do_push && !q_full) begin
            wp_reg  <= (wp_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wp_reg + QPTR_W'(1);
            cnt_reg <= cnt_reg + QCNT_W'(1);
        end else if (cmd.pop && !q_empty) begin
            rp_reg  <= (rp_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rp_reg + QPTR_W'(1);
            cnt_reg <= cnt_reg - QCNT_W'(1);
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (cmd.pop) begin
            if (q_empty) begin
                out_reg <= '{queue_empty: 1'b1, key_number: '0, event_kind: '0,
                             pending_count: '0};
            end else begin
                out_reg <= '{queue_empty: 1'b0,
                             key_number: head[ENTRY_W-1:KIND_W],
                             event_kind: head[KIND_W-1:0],
                             pending_count: PEND_W'(cnt_reg - QCNT_W'(1))};
            end
        end
    end

    assign m_data = out_reg;

endmodule

/* design/kdeq_ctrl.sv */
// Controller: sequences the key walk, the extra queue write and the read; owns result valid.
// Depends on kdeq_pkg; drives kdeq_datapath.
module kdeq_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    input  logic                   s_func,
    output logic                   s_ready,
    output logic                   m_valid,
    input  logic                   m_ready,
    input  kdeq_pkg::kdeq_status_t status,
    output kdeq_pkg::kdeq_cmd_t    cmd
);
    import kdeq_pkg::*;

    kdeq_state_t state_reg;
    kdeq_state_t state_next;
    logic        last_reg;
    logic        last_next;
    logic        valid_reg;
    logic        valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            last_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            last_reg  <= last_next;
            valid_reg <= valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        last_next  = last_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load = 1'b1;
                    if (s_func) begin
                        state_next = ST_READ;
                    end else if (!status.keys_none) begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
                if (status.need_second) begin
                    last_next  = status.scan_last;
                    state_next = ST_SECOND;
                end else if (status.scan_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_SECOND: begin
                cmd.push_second = 1'b1;
                state_next      = last_reg ? ST_IDLE : ST_SCAN;
            end
            ST_READ: begin
                if (!valid_reg || m_ready) begin
                    cmd.pop    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        valid_next = valid_reg;
        if (cmd.pop) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    assign m_valid = valid_reg;

endmodule

/* design/kdeq_checker.sv */
// Port-level checks on the result channel of the key debounce event queue, and its bind.
// Depends on kdeq_pkg and key_debounce_event_queue_assert.svh.
`include "key_debounce_event_queue_assert.svh"

module kdeq_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                m_valid,
    input logic                m_ready,
    input kdeq_pkg::kdeq_out_t m_data
);
    import kdeq_pkg::*;

    `KDEQ_ASSERT_NEXT(a_hold, m_valid && !m_ready, m_valid && $stable(m_data), "result dropped or changed while stalled")
    `KDEQ_ASSERT_NOW(a_empty_zero, m_valid && m_data.queue_empty, (m_data.key_number == '0) && (m_data.event_kind == '0) && (m_data.pending_count == '0), "empty read carries nonzero fields")
    `KDEQ_ASSERT_NOW(a_key_range, m_valid && !m_data.queue_empty, (m_data.key_number != '0) && (m_data.key_number <= NUM_W'(MAX_KEYS)), "popped key number out of range")
    `KDEQ_ASSERT_NOW(a_pending, m_valid && !m_data.queue_empty, m_data.pending_count < PEND_W'(QUEUE_DEPTH), "pending count above queue depth less one")

endmodule

bind key_debounce_event_queue kdeq_checker u_kdeq_checker (.*);
